/* rtl/core/riscv_privileged_csr_file_core_defines.svh */
// Assertion macros shared by the CSR file RTL.
`ifndef RISCV_PRIVILEGED_CSR_FILE_CORE_DEFINES_SVH
`define RISCV_PRIVILEGED_CSR_FILE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RPCSR_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RPCSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rpcsr_pkg.sv */
// Types, CSR addresses and fixed masks for the RV32 M/S CSR file.
package rpcsr_pkg;

  typedef enum logic [1:0] {
    REQ_READ     = 2'd0,
    REQ_WRITE    = 2'd1,
    REQ_SET_PEND = 2'd2,
    REQ_CLR_PEND = 2'd3
  } req_kind_t;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISA          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSTATUS_WMASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SSTATUS_VMASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDELEG_WMASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTEREN     = 3'd4;

  localparam logic [31:0] MISA_RST          = 32'd1074008321;
  localparam logic [31:0] MSTATUS_WMASK_RST = 32'd8264106;
  localparam logic [31:0] SSTATUS_VMASK_RST = 32'd786722;
  localparam logic [31:0] MEDELEG_WMASK_RST = 32'd46079;
  localparam logic [31:0] COUNTEREN_RST     = 32'd0;

  localparam logic [31:0] MIE_BITS   = 32'h0000_0AAA;
  localparam logic [31:0] S_INT_BITS = 32'h0000_0222;
  localparam logic [31:0] SSIP_BIT   = 32'h0000_0002;
  localparam logic [31:0] TVEC_BITS  = 32'hFFFF_FFFD;
  localparam logic [31:0] EPC_BITS   = 32'hFFFF_FFFC;

  localparam logic [11:0] CSR_SSTATUS    = 12'h100;
  localparam logic [11:0] CSR_SIE        = 12'h104;
  localparam logic [11:0] CSR_STVEC      = 12'h105;
  localparam logic [11:0] CSR_SCOUNTEREN = 12'h106;
  localparam logic [11:0] CSR_SSCRATCH   = 12'h140;
  localparam logic [11:0] CSR_SEPC       = 12'h141;
  localparam logic [11:0] CSR_SCAUSE     = 12'h142;
  localparam logic [11:0] CSR_STVAL      = 12'h143;
  localparam logic [11:0] CSR_SIP        = 12'h144;
  localparam logic [11:0] CSR_SATP       = 12'h180;
  localparam logic [11:0] CSR_MSTATUS    = 12'h300;
  localparam logic [11:0] CSR_MISA       = 12'h301;
  localparam logic [11:0] CSR_MEDELEG    = 12'h302;
  localparam logic [11:0] CSR_MIDELEG    = 12'h303;
  localparam logic [11:0] CSR_MIE        = 12'h304;
  localparam logic [11:0] CSR_MTVEC      = 12'h305;
  localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
  localparam logic [11:0] CSR_MEPC       = 12'h341;
  localparam logic [11:0] CSR_MCAUSE     = 12'h342;
  localparam logic [11:0] CSR_MTVAL      = 12'h343;
  localparam logic [11:0] CSR_MIP        = 12'h344;
  localparam logic [11:0] CSR_MVENDORID  = 12'hF11;
  localparam logic [11:0] CSR_MARCHID    = 12'hF12;
  localparam logic [11:0] CSR_MIMPID     = 12'hF13;
  localparam logic [11:0] CSR_MHARTID    = 12'hF14;
  localparam logic [11:0] CSR_MCONFIGPTR = 12'hF15;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  priv_mode;
    logic [11:0] csr_addr;
    logic [31:0] write_data;
    logic [4:0]  irq_bit;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        legal;
  } rsp_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0] mach_status;
    logic [31:0] exc_deleg;
    logic [31:0] int_deleg;
    logic [31:0] int_enable;
    logic [31:0] int_pending;
    logic [31:0] mach_trap_vector;
    logic [31:0] mach_scratch;
    logic [31:0] mach_exc_pc;
    logic [31:0] mach_cause;
    logic [31:0] mach_trap_value;
    logic [31:0] sup_trap_vector;
    logic [31:0] sup_scratch;
    logic [31:0] sup_exc_pc;
    logic [31:0] sup_cause;
    logic [31:0] sup_trap_value;
    logic [31:0] addr_translation;
  } csr_state_t;

  function automatic logic [31:0] merge(logic [31:0] old, logic [31:0] val,
                                        logic [31:0] mask);
    return (old & ~mask) | (val & mask);
  endfunction

endpackage

/* rtl/core/rpcsr_req_if.sv */
// Request channel: valid/ready with one CSR access as payload.
interface rpcsr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  priv_mode;
  logic [11:0] csr_addr;
  logic [31:0] write_data;
  logic [4:0]  irq_bit;

  modport source (output valid, req_type, priv_mode, csr_addr, write_data, irq_bit,
                  input ready);
  modport sink (input valid, req_type, priv_mode, csr_addr, write_data, irq_bit,
                output ready);
endinterface

/* rtl/core/rpcsr_rsp_if.sv */
// Response channel: valid/ready with read data and legal flag.
interface rpcsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        legal;

  modport source (output valid, read_data, legal, input ready);
  modport sink (input valid, read_data, legal, output ready);
endinterface

/* rtl/core/rpcsr_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
interface rpcsr_cfg_if;
  import rpcsr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/riscv_privileged_csr_file_core.sv */
// Top level of the RV32 machine/supervisor CSR file.
//
// Channels:
//   req : CSR access transactions (read, write, set or clear a mip bit),
//         each carrying type, privilege, address, write data and bit index.
//   rsp : one transaction per request, in order: read_data and legal.
//   cfg : register writes (misa value, mstatus/sstatus/medeleg masks,
//         scounteren value); always ready, meant to be used while idle.
// Path: an accepted request is held in the input register, then decoded
//   and applied to the CSR state as it moves into the response register,
//   which drives rsp until the response is taken.
// Throughput: one transaction per cycle unless rsp stalls; the decode and
//   state update sit in a single combinational stage between the two registers.
// Stall: when rsp is held off, the response register keeps its transaction,
//   the input register fills with the next request, and req.ready drops
//   until rsp.ready returns. No request is lost or applied twice.
// Reset: rst is synchronous; all CSRs clear to zero, configuration takes
//   its default values, both pipeline registers empty.
`include "riscv_privileged_csr_file_core_defines.svh"

module riscv_privileged_csr_file_core
  import rpcsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rpcsr_req_if.sink    req,
  rpcsr_rsp_if.source  rsp,
  rpcsr_cfg_if.sink    cfg
);

  // input register
  logic    s1_valid;
  req_t    s1_req;
  // response register
  logic    out_valid;
  rsp_t    out_rsp;

  rsp_t    unit_rsp;
  cfg_wr_t cfg_wr;
  logic    advance;

  // the input stage moves on whenever the response slot is free or draining
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  assign cfg_wr.en    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req.req_type   <= req.req_type;
      s1_req.priv_mode  <= req.priv_mode;
      s1_req.csr_addr   <= req.csr_addr;
      s1_req.write_data <= req.write_data;
      s1_req.irq_bit    <= req.irq_bit;
    end
  end

  // state is committed exactly when the transaction moves to the response slot
  rpcsr_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .req    (s1_req),
    .cfg    (cfg_wr),
    .rsp    (unit_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= unit_rsp;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rsp.read_data;
  assign rsp.legal     = out_rsp.legal;

  `RPCSR_ASSERT_IMM(a_illegal_zero, rsp.valid && !rsp.legal, rsp.read_data == '0,
                    "illegal response carries nonzero data")
  `RPCSR_ASSERT_NXT(a_stall_keeps_s1, s1_valid && rsp.valid && !rsp.ready, s1_valid,
                    "input stage dropped a transaction during a stall")
  `RPCSR_ASSERT_IMM(a_empty_takes, !s1_valid, req.ready,
                    "empty input stage refused a request")

endmodule

/* rtl/core/rpcsr_unit.sv */
// CSR state, configuration registers and access decode.
`include "riscv_privileged_csr_file_core_defines.svh"

module rpcsr_unit
  import rpcsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    commit,
  input  req_t    req,
  input  cfg_wr_t cfg,
  output rsp_t    rsp
);

  csr_state_t  st;
  csr_state_t  st_next;
  logic [31:0] misa_value;
  logic [31:0] mstatus_write_mask;
  logic [31:0] sstatus_view_mask;
  logic [31:0] medeleg_write_mask;
  logic [31:0] counteren_value;

  logic        is_m;
  logic        is_s;
  logic [31:0] pend_mask;
  logic [31:0] wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      misa_value         <= MISA_RST;
      mstatus_write_mask <= MSTATUS_WMASK_RST;
      sstatus_view_mask  <= SSTATUS_VMASK_RST;
      medeleg_write_mask <= MEDELEG_WMASK_RST;
      counteren_value    <= COUNTEREN_RST;
    end else if (cfg.en) begin
      unique case (cfg.index)
        CFG_MISA:          misa_value         <= cfg.data;
        CFG_MSTATUS_WMASK: mstatus_write_mask <= cfg.data;
        CFG_SSTATUS_VMASK: sstatus_view_mask  <= cfg.data;
        CFG_MEDELEG_WMASK: medeleg_write_mask <= cfg.data;
        CFG_COUNTEREN:     counteren_value    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_m      = (req.priv_mode == PRIV_M);
    is_s      = is_m || (req.priv_mode == PRIV_S);
    wd        = req.write_data;
    pend_mask = (32'd1 << req.irq_bit) & MIE_BITS;
    st_next   = st;
    rsp       = '0;

    unique case (req_kind_t'(req.req_type))
      REQ_READ: begin
        unique case (req.csr_addr)
          CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID, CSR_MCONFIGPTR:
            rsp.legal = is_m;
          CSR_MSTATUS: begin
            rsp.legal = is_m; rsp.read_data = st.mach_status & mstatus_write_mask;
          end
          CSR_MISA:     begin rsp.legal = is_m; rsp.read_data = misa_value;          end
          CSR_MEDELEG:  begin rsp.legal = is_m; rsp.read_data = st.exc_deleg;        end
          CSR_MIDELEG:  begin rsp.legal = is_m; rsp.read_data = st.int_deleg;        end
          CSR_MIE:      begin rsp.legal = is_m; rsp.read_data = st.int_enable;       end
          CSR_MTVEC:    begin rsp.legal = is_m; rsp.read_data = st.mach_trap_vector; end
          CSR_MSCRATCH: begin rsp.legal = is_m; rsp.read_data = st.mach_scratch;     end
          CSR_MEPC:     begin rsp.legal = is_m; rsp.read_data = st.mach_exc_pc;      end
          CSR_MCAUSE:   begin rsp.legal = is_m; rsp.read_data = st.mach_cause;       end
          CSR_MTVAL:    begin rsp.legal = is_m; rsp.read_data = st.mach_trap_value;  end
          CSR_MIP:      begin rsp.legal = is_m; rsp.read_data = st.int_pending;      end
          CSR_SSTATUS: begin
            rsp.legal = is_s; rsp.read_data = st.mach_status & sstatus_view_mask;
          end
          CSR_SIE: begin
            rsp.legal = is_s; rsp.read_data = st.int_enable & st.int_deleg;
          end
          CSR_STVEC:      begin rsp.legal = is_s; rsp.read_data = st.sup_trap_vector; end
          CSR_SCOUNTEREN: begin rsp.legal = is_s; rsp.read_data = counteren_value;    end
          CSR_SSCRATCH:   begin rsp.legal = is_s; rsp.read_data = st.sup_scratch;     end
          CSR_SEPC:       begin rsp.legal = is_s; rsp.read_data = st.sup_exc_pc;      end
          CSR_SCAUSE:     begin rsp.legal = is_s; rsp.read_data = st.sup_cause;       end
          CSR_STVAL:      begin rsp.legal = is_s; rsp.read_data = st.sup_trap_value;  end
          CSR_SIP: begin
            rsp.legal = is_s; rsp.read_data = st.int_pending & st.int_deleg;
          end
          CSR_SATP: begin rsp.legal = is_s; rsp.read_data = st.addr_translation; end
          default: ;
        endcase
        // illegal reads return zero
        if (!rsp.legal) begin
          rsp.read_data = '0;
        end
      end

      REQ_WRITE: begin
        unique case (req.csr_addr)
          CSR_MSTATUS: begin
            rsp.legal = is_m;
            if (is_m) st_next.mach_status = merge(st.mach_status, wd, mstatus_write_mask);
          end
          CSR_MISA: rsp.legal = is_m;
          CSR_MEDELEG: begin
            rsp.legal = is_m;
            if (is_m) st_next.exc_deleg = wd & medeleg_write_mask;
          end
          CSR_MIDELEG: begin
            rsp.legal = is_m;
            if (is_m) st_next.int_deleg = wd & S_INT_BITS;
          end
          CSR_MIE: begin
            rsp.legal = is_m;
            if (is_m) st_next.int_enable = merge(st.int_enable, wd, MIE_BITS);
          end
          CSR_MTVEC: begin
            rsp.legal = is_m;
            if (is_m) st_next.mach_trap_vector = wd & TVEC_BITS;
          end
          CSR_MSCRATCH: begin
            rsp.legal = is_m;
            if (is_m) st_next.mach_scratch = wd;
          end
          CSR_MEPC: begin
            rsp.legal = is_m;
            if (is_m) st_next.mach_exc_pc = wd & EPC_BITS;
          end
          CSR_MCAUSE: begin
            rsp.legal = is_m;
            if (is_m) st_next.mach_cause = wd;
          end
          CSR_MTVAL: begin
            rsp.legal = is_m;
            if (is_m) st_next.mach_trap_value = wd;
          end
          CSR_MIP: begin
            rsp.legal = is_m;
            if (is_m) st_next.int_pending = merge(st.int_pending, wd, S_INT_BITS);
          end
          CSR_SSTATUS: begin
            rsp.legal = is_s;
            if (is_s) st_next.mach_status = merge(st.mach_status, wd, sstatus_view_mask);
          end
          CSR_SIE: begin
            rsp.legal = is_s;
            if (is_s) begin
              st_next.int_enable = merge(st.int_enable, wd, S_INT_BITS & st.int_deleg);
            end
          end
          CSR_STVEC: begin
            rsp.legal = is_s;
            if (is_s) st_next.sup_trap_vector = wd & TVEC_BITS;
          end
          CSR_SCOUNTEREN: rsp.legal = is_s;
          CSR_SSCRATCH: begin
            rsp.legal = is_s;
            if (is_s) st_next.sup_scratch = wd;
          end
          CSR_SEPC: begin
            rsp.legal = is_s;
            if (is_s) st_next.sup_exc_pc = wd & EPC_BITS;
          end
          CSR_SCAUSE: begin
            rsp.legal = is_s;
            if (is_s) st_next.sup_cause = wd;
          end
          CSR_STVAL: begin
            rsp.legal = is_s;
            if (is_s) st_next.sup_trap_value = wd;
          end
          CSR_SIP: begin
            rsp.legal = is_s;
            if (is_s) begin
              st_next.int_pending = merge(st.int_pending, wd, SSIP_BIT & st.int_deleg);
            end
          end
          CSR_SATP: begin
            // unsupported modes are dropped silently
            rsp.legal = is_s;
            if (is_s && ((wd == '0) || wd[31])) st_next.addr_translation = wd;
          end
          default: ;
        endcase
      end

      REQ_SET_PEND: begin
        rsp.legal           = 1'b1;
        st_next.int_pending = st.int_pending | pend_mask;
      end

      REQ_CLR_PEND: begin
        rsp.legal           = 1'b1;
        st_next.int_pending = st.int_pending & ~pend_mask;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (commit) begin
      st <= st_next;
    end
  end

  `RPCSR_ASSERT_IMM(a_pend_bits, 1'b1, (st.int_pending & ~MIE_BITS) == '0,
                    "mip holds a bit outside the interrupt set")
  `RPCSR_ASSERT_IMM(a_deleg_bits, 1'b1, (st.int_deleg & ~S_INT_BITS) == '0,
                    "mideleg holds a non-supervisor bit")
  `RPCSR_ASSERT_NXT(a_state_hold, !commit && !rst, $stable(st),
                    "CSR state changed without a commit")

endmodule

/* tb/csr_file_checker.sv */
// Scoreboard for the CSR file: shadows the CSRs and checks every response.
module csr_file_checker
  import rpcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rpcsr_req_if        req,
  rpcsr_rsp_if        rsp,
  rpcsr_cfg_if        cfg,
  output int unsigned mismatches,
  output int unsigned pending_rsps,
  output int unsigned checked_rsps,
  output int unsigned legal_rsps
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_kind_t   kind;
    logic [1:0]  priv;
    logic [11:0] addr;
    rsp_t        rsp;
  } csr_outcome_t;

  // shadow CSRs and configuration
  csr_state_t  shadow;
  logic [31:0] misa_val;
  logic [31:0] mstatus_wmask;
  logic [31:0] sstatus_vmask;
  logic [31:0] medeleg_wmask;
  logic [31:0] counteren_val;

  csr_outcome_t outcome_q[$];
  csr_outcome_t head;
  csr_outcome_t fresh;

  function automatic rsp_t predict_access(req_kind_t kind, logic [1:0] priv,
                                          logic [11:0] addr, logic [31:0] wdata,
                                          logic [4:0] irq);
    rsp_t        r;
    logic [31:0] wm;
    logic [31:0] pend_mask;
    r = '0;
    pend_mask = (32'd1 << irq) & MIE_BITS;
    case (kind)
      REQ_READ: begin
        if (priv == PRIV_M) begin
          r.legal = 1'b1;
          case (addr)
            CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID, CSR_MCONFIGPTR:
              r.read_data = '0;
            CSR_MSTATUS:  r.read_data = shadow.mach_status & mstatus_wmask;
            CSR_MISA:     r.read_data = misa_val;
            CSR_MEDELEG:  r.read_data = shadow.exc_deleg;
            CSR_MIDELEG:  r.read_data = shadow.int_deleg;
            CSR_MIE:      r.read_data = shadow.int_enable;
            CSR_MTVEC:    r.read_data = shadow.mach_trap_vector;
            CSR_MSCRATCH: r.read_data = shadow.mach_scratch;
            CSR_MEPC:     r.read_data = shadow.mach_exc_pc;
            CSR_MCAUSE:   r.read_data = shadow.mach_cause;
            CSR_MTVAL:    r.read_data = shadow.mach_trap_value;
            CSR_MIP:      r.read_data = shadow.int_pending;
            default:      r.legal = 1'b0;
          endcase
        end
        if (!r.legal && (priv == PRIV_M || priv == PRIV_S)) begin
          r.legal = 1'b1;
          case (addr)
            CSR_SSTATUS:    r.read_data = shadow.mach_status & sstatus_vmask;
            CSR_SIE:        r.read_data = shadow.int_enable & shadow.int_deleg;
            CSR_STVEC:      r.read_data = shadow.sup_trap_vector;
            CSR_SCOUNTEREN: r.read_data = counteren_val;
            CSR_SSCRATCH:   r.read_data = shadow.sup_scratch;
            CSR_SEPC:       r.read_data = shadow.sup_exc_pc;
            CSR_SCAUSE:     r.read_data = shadow.sup_cause;
            CSR_STVAL:      r.read_data = shadow.sup_trap_value;
            CSR_SIP:        r.read_data = shadow.int_pending & shadow.int_deleg;
            CSR_SATP:       r.read_data = shadow.addr_translation;
            default:        r.legal = 1'b0;
          endcase
        end
        if (!r.legal)
          r.read_data = '0;
      end
      REQ_WRITE: begin
        if (priv == PRIV_M) begin
          r.legal = 1'b1;
          case (addr)
            CSR_MSTATUS:
              shadow.mach_status = (shadow.mach_status & ~mstatus_wmask)
                                 | (wdata & mstatus_wmask);
            CSR_MISA: ;
            CSR_MEDELEG:  shadow.exc_deleg = wdata & medeleg_wmask;
            CSR_MIDELEG:  shadow.int_deleg = wdata & S_INT_BITS;
            CSR_MIE:
              shadow.int_enable = (shadow.int_enable & ~MIE_BITS) | (wdata & MIE_BITS);
            CSR_MTVEC:    shadow.mach_trap_vector = wdata & TVEC_BITS;
            CSR_MSCRATCH: shadow.mach_scratch = wdata;
            CSR_MEPC:     shadow.mach_exc_pc = wdata & EPC_BITS;
            CSR_MCAUSE:   shadow.mach_cause = wdata;
            CSR_MTVAL:    shadow.mach_trap_value = wdata;
            CSR_MIP:
              shadow.int_pending = (shadow.int_pending & ~S_INT_BITS)
                                 | (wdata & S_INT_BITS);
            default:      r.legal = 1'b0;
          endcase
        end
        if (!r.legal && (priv == PRIV_M || priv == PRIV_S)) begin
          r.legal = 1'b1;
          case (addr)
            CSR_SSTATUS:
              shadow.mach_status = (shadow.mach_status & ~sstatus_vmask)
                                 | (wdata & sstatus_vmask);
            CSR_SIE: begin
              wm = S_INT_BITS & shadow.int_deleg;
              shadow.int_enable = (shadow.int_enable & ~wm) | (wdata & wm);
            end
            CSR_STVEC:      shadow.sup_trap_vector = wdata & TVEC_BITS;
            CSR_SCOUNTEREN: ;
            CSR_SSCRATCH:   shadow.sup_scratch = wdata;
            CSR_SEPC:       shadow.sup_exc_pc = wdata & EPC_BITS;
            CSR_SCAUSE:     shadow.sup_cause = wdata;
            CSR_STVAL:      shadow.sup_trap_value = wdata;
            CSR_SIP: begin
              wm = SSIP_BIT & shadow.int_deleg;
              shadow.int_pending = (shadow.int_pending & ~wm) | (wdata & wm);
            end
            CSR_SATP:
              // only bare (zero) or a mode with bit 31 set takes effect
              if (wdata == '0 || wdata[31])
                shadow.addr_translation = wdata;
            default:        r.legal = 1'b0;
          endcase
        end
      end
      REQ_SET_PEND: begin
        shadow.int_pending = shadow.int_pending | pend_mask;
        r.legal = 1'b1;
      end
      default: begin
        shadow.int_pending = shadow.int_pending & ~pend_mask;
        r.legal = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic log_failure(string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow        = '0;
      misa_val      = MISA_RST;
      mstatus_wmask = MSTATUS_WMASK_RST;
      sstatus_vmask = SSTATUS_VMASK_RST;
      medeleg_wmask = MEDELEG_WMASK_RST;
      counteren_val = COUNTEREN_RST;
      outcome_q.delete();
      mismatches    = 0;
      pending_rsps  = 0;
      checked_rsps  = 0;
      legal_rsps    = 0;
    end else begin
      // response first: it always belongs to an older request
      if (rsp.valid && rsp.ready) begin
        checked_rsps++;
        if (rsp.legal === 1'b1)
          legal_rsps++;
        if (outcome_q.size() == 0) begin
          log_failure($sformatf("response with nothing outstanding: data %08h legal %0b",
                                rsp.read_data, rsp.legal));
        end else begin
          head = outcome_q.pop_front();
          if (rsp.read_data !== head.rsp.read_data || rsp.legal !== head.rsp.legal)
            log_failure($sformatf(
              "%s priv %0d csr %03h: read_data exp %08h got %08h, legal exp %0b got %0b",
              head.kind.name(), head.priv, head.addr, head.rsp.read_data,
              rsp.read_data, head.rsp.legal, rsp.legal));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MISA:          misa_val = cfg.data;
          CFG_MSTATUS_WMASK: mstatus_wmask = cfg.data;
          CFG_SSTATUS_VMASK: sstatus_vmask = cfg.data;
          CFG_MEDELEG_WMASK: medeleg_wmask = cfg.data;
          CFG_COUNTEREN:     counteren_val = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        fresh.kind = req_kind_t'(req.req_type);
        fresh.priv = req.priv_mode;
        fresh.addr = req.csr_addr;
        fresh.rsp  = predict_access(fresh.kind, req.priv_mode, req.csr_addr,
                                    req.write_data, req.irq_bit);
        outcome_q.push_back(fresh);
      end
      pending_rsps = outcome_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the CSR file testbench: clock, reset, traffic generation and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpcsr_pkg::*;

  // reserved privilege encoding, never legal for CSR reads and writes
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  // config index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int unsigned NUM_SETTINGS      = 8;
  localparam int unsigned ITEMS_PER_SETTING = 200;
  // room for a stray response to pass the input and response registers
  localparam int unsigned DRAIN_CYCLES      = 4;
  // worst case per item is a long gap, a long stall and the pipeline delay,
  // for ~1650 items; this leaves a wide margin
  localparam int unsigned CYCLE_LIMIT       = 1_000_000;

  localparam logic [11:0] KNOWN_CSRS [26] = '{
    CSR_SSTATUS, CSR_SIE, CSR_STVEC, CSR_SCOUNTEREN, CSR_SSCRATCH, CSR_SEPC,
    CSR_SCAUSE, CSR_STVAL, CSR_SIP, CSR_SATP,
    CSR_MSTATUS, CSR_MISA, CSR_MEDELEG, CSR_MIDELEG, CSR_MIE, CSR_MTVEC,
    CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL, CSR_MIP,
    CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID, CSR_MCONFIGPTR
  };

  logic clk;
  logic rst;

  rpcsr_req_if req_ch ();
  rpcsr_rsp_if rsp_ch ();
  rpcsr_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned pending_rsps;
  int unsigned checked_rsps;
  int unsigned legal_rsps;

  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned cfg_writes;
  // phases with no idling on one side or the other
  bit          steady_source;
  bit          steady_sink;

  riscv_privileged_csr_file_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  csr_file_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .pending_rsps (pending_rsps),
    .checked_rsps (checked_rsps),
    .legal_rsps   (legal_rsps)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65)
      return 0;
    else if (roll < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(6, 30);
  endfunction

  // Data with a bias toward edge patterns: zero, all ones, one-hot,
  // one-cold, and values with bit 31 set (satp mode).
  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return ~(32'd1 << $urandom_range(0, 31));
      4:       return {1'b1, 31'($urandom)};
      default: return $urandom();
    endcase
  endfunction

  // One request transaction. Fields are set at the falling edge, the
  // transaction completes at the first rising edge with ready high, then
  // the source may idle with junk on the payload.
  task automatic send_access(req_kind_t kind, logic [1:0] priv, logic [11:0] addr,
                             logic [31:0] wdata, logic [4:0] irq);
    int unsigned gap;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.priv_mode  <= priv;
    req_ch.csr_addr   <= addr;
    req_ch.write_data <= wdata;
    req_ch.irq_bit    <= irq;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    items_sent++;
    gap = steady_source ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= 2'($urandom);
      req_ch.priv_mode  <= 2'($urandom);
      req_ch.csr_addr   <= 12'($urandom);
      req_ch.write_data <= $urandom();
      req_ch.irq_bit    <= 5'($urandom);
    end
  endtask

  // Config register write; only issued while the CSR file is idle.
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Drop valid and wait until every response has been taken.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsps != 0)
      @(negedge clk);
  endtask

  // Response side: runs of ready separated by stalls of random length.
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    run_left     = 0;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_sink || run_left > 0) begin
        rsp_ch.ready <= 1'b1;
        if (run_left > 0)
          run_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        run_left   = $urandom_range(0, 12);
        stall_left = pick_gap();
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("riscv_privileged_csr_file_core test failed");
    $finish;
  end

  initial begin
    logic [31:0] misa_v, mstat_v, sstat_v, medeleg_v, cnten_v;
    req_kind_t   kind;
    logic [1:0]  priv;
    logic [11:0] addr;
    int unsigned roll;
    int unsigned target;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_READ;
    req_ch.priv_mode  = PRIV_M;
    req_ch.csr_addr   = '0;
    req_ch.write_data = '0;
    req_ch.irq_bit    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_MISA;
    cfg_ch.data       = '0;
    steady_source     = 1'b0;
    steady_sink       = 1'b0;
    items_sent        = 0;
    cfg_writes        = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, reset configuration ----
    send_access(REQ_READ,  PRIV_M, CSR_MISA,    '0, 5'd0);   // reset misa value
    send_access(REQ_WRITE, PRIV_M, CSR_MSTATUS, '1, 5'd31);  // only implemented bits stick
    send_access(REQ_READ,  PRIV_M, CSR_MSTATUS, '0, 5'd0);
    send_access(REQ_READ,  PRIV_S, CSR_SSTATUS, '0, 5'd0);   // masked view
    send_access(REQ_WRITE, PRIV_S, CSR_SSTATUS, '0, 5'd0);   // masked merge
    // nothing delegated yet: sie write must not change mie
    send_access(REQ_WRITE, PRIV_S, CSR_SIE,     '1, 5'd0);
    send_access(REQ_WRITE, PRIV_M, CSR_MIDELEG, '1, 5'd0);
    send_access(REQ_WRITE, PRIV_S, CSR_SIE,     '1, 5'd0);
    send_access(REQ_WRITE, PRIV_S, CSR_SIP,     '1, 5'd0);   // only SSIP is writable
    send_access(REQ_READ,  PRIV_M, CSR_MIE,     '0, 5'd0);
    // pending bits: one inside the interrupt mask, one outside, one cleared
    send_access(REQ_SET_PEND, PRIV_M, '0, '1, 5'd11);
    send_access(REQ_SET_PEND, PRIV_U, '1, '1, 5'd0);
    send_access(REQ_CLR_PEND, PRIV_RSVD, '0, '0, 5'd1);
    send_access(REQ_READ,  PRIV_S, CSR_SIP,     '0, 5'd0);
    // satp: unsupported mode ignored, bit 31 set takes effect
    send_access(REQ_WRITE, PRIV_S, CSR_SATP, 32'h0000_1234, 5'd0);
    send_access(REQ_WRITE, PRIV_S, CSR_SATP, 32'h8000_0001, 5'd0);
    send_access(REQ_READ,  PRIV_S, CSR_SATP, '0, 5'd0);
    // privilege violations
    send_access(REQ_READ,  PRIV_U,    CSR_SSTATUS, '0, 5'd0);
    send_access(REQ_READ,  PRIV_RSVD, CSR_MSTATUS, '0, 5'd0);
    send_access(REQ_WRITE, PRIV_S,    CSR_MSTATUS, '1, 5'd0);
    // read-only ID registers, ignored writes, unimplemented address
    send_access(REQ_WRITE, PRIV_M, CSR_MVENDORID,  '1, 5'd0);
    send_access(REQ_READ,  PRIV_M, CSR_MHARTID,    '0, 5'd0);
    send_access(REQ_WRITE, PRIV_M, CSR_MISA,       '0, 5'd0);
    send_access(REQ_WRITE, PRIV_S, CSR_SCOUNTEREN, '1, 5'd0);
    send_access(REQ_READ,  PRIV_M, 12'hFFF,        '0, 5'd0);

    // ---- random part, one block per config setting ----
    // first all-ones, then all-zeros, random ones in between, defaults last
    for (int unsigned p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      if (p == 0) begin
        {misa_v, mstat_v, sstat_v, medeleg_v, cnten_v} = {5{32'hFFFF_FFFF}};
      end else if (p == 1) begin
        {misa_v, mstat_v, sstat_v, medeleg_v, cnten_v} = '0;
      end else if (p == NUM_SETTINGS - 1) begin
        misa_v    = MISA_RST;
        mstat_v   = MSTATUS_WMASK_RST;
        sstat_v   = SSTATUS_VMASK_RST;
        medeleg_v = MEDELEG_WMASK_RST;
        cnten_v   = COUNTEREN_RST;
      end else begin
        misa_v    = pick_data();
        mstat_v   = pick_data();
        sstat_v   = pick_data();
        medeleg_v = pick_data();
        cnten_v   = pick_data();
      end
      write_setting(CFG_MISA,          misa_v);
      write_setting(CFG_MSTATUS_WMASK, mstat_v);
      write_setting(CFG_SSTATUS_VMASK, sstat_v);
      write_setting(CFG_MEDELEG_WMASK, medeleg_v);
      write_setting(CFG_COUNTEREN,     cnten_v);
      if (p == 2)
        write_setting(CFG_UNUSED, $urandom());

      steady_source = ($urandom_range(0, 3) == 0);
      steady_sink   = ($urandom_range(0, 3) == 0);

      target = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 40)      kind = REQ_READ;
        else if (roll < 75) kind = REQ_WRITE;
        else if (roll < 88) kind = REQ_SET_PEND;
        else                kind = REQ_CLR_PEND;
        // mostly machine and supervisor so accesses get past the privilege check
        roll = $urandom_range(0, 99);
        if (roll < 60)      priv = PRIV_M;
        else if (roll < 85) priv = PRIV_S;
        else if (roll < 93) priv = PRIV_U;
        else                priv = PRIV_RSVD;
        if ($urandom_range(0, 9) < 8)
          addr = KNOWN_CSRS[$urandom_range(0, 25)];
        else
          addr = 12'($urandom);
        send_access(kind, priv, addr, pick_data(), 5'($urandom));
        // read back a written CSR about a third of the time
        if (kind == REQ_WRITE && $urandom_range(0, 2) == 0)
          send_access(REQ_READ, priv, addr, pick_data(), 5'($urandom));
      end
    end

    steady_source = 1'b0;
    steady_sink   = 1'b1;
    drain();
    // catch any stray response after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d CSR transactions checked, %0d legal and %0d illegal,",
             checked_rsps, legal_rsps, checked_rsps - legal_rsps);
    $display("across %0d config settings (%0d register writes), %0d mismatches",
             NUM_SETTINGS + 1, cfg_writes, mismatches);
    if (mismatches == 0)
      $display("riscv_privileged_csr_file_core test passed");
    else
      $display("riscv_privileged_csr_file_core test failed");
    $finish;
  end

endmodule

/* riscv_privileged_csr_file_core.f */
+incdir+rtl/core
rtl/core/rpcsr_pkg.sv
rtl/core/rpcsr_req_if.sv
rtl/core/rpcsr_rsp_if.sv
rtl/core/rpcsr_cfg_if.sv
rtl/core/rpcsr_unit.sv
rtl/core/riscv_privileged_csr_file_core.sv
tb/csr_file_checker.sv
tb/testbench.sv
